// ----- design/sabs_pkg.sv -----
// Shared constants, codes and types of the sorted array binary search block.
`timescale 1ns / 1ps
package sabs_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LO_W   = $clog2(DEPTH + 1);
	localparam int BND_W  = LO_W + 1;
	localparam int CNT_W  = 11;
	localparam int VAL_W  = 32;
	localparam int PRB_W  = 4;
	localparam logic [PRB_W-1:0] PRB_MAX = '1;

	localparam int IN_FLD_W    = ADDR_W + 2 * VAL_W;
	localparam int IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8;
	localparam int OUT_FLD_W   = 1 + ADDR_W + PRB_W;
	localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] position;
		logic [PRB_W-1:0]  probe_count;
	} sabs_result_t;

endpackage

// ----- design/sorted_array_binary_search.sv -----
// Top level of the sorted array binary search block.
//
//  Channel  Direction  Contents
//  s_*      in         tuser: action; tdata: entry_index, entry_value, search_target
//  m_*      out        tdata: found, position, probe_count
//  cfg_*    in         element_count write
//
// A load item writes the store. A search item runs one probe after another
// until a hit or until its bounds cross: each probe is one read of the single
// store port followed by one compare.
// The input is not ready while a search runs or waits for the output register.
// Reset clears control state and element_count; the store holds no reset value.
`timescale 1ns / 1ps
module sorted_array_binary_search
	import sabs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // entry_index, entry_value, search_target
	input  logic                   s_tuser,  // action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // found, position, probe_count
	input  logic                   cfg_wr_en,
	input  logic [CNT_W-1:0]       cfg_wr_data
);

	logic              in_acc;
	logic              seq_idle;
	logic              seq_done;
	logic              out_free;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  rd_data;
	logic [ADDR_W-1:0] entry_index;
	logic [VAL_W-1:0]  entry_value;
	logic [VAL_W-1:0]  search_target;
	sabs_result_t      seq_result;
	sabs_result_t      out_q;
	logic              m_tvalid_q;

	assign entry_index   = s_tdata[ADDR_W-1:0];
	assign entry_value   = s_tdata[ADDR_W +: VAL_W];
	assign search_target = s_tdata[ADDR_W + VAL_W +: VAL_W];

	assign s_tready = seq_idle;
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	sabs_store u_store (
		.clk     (clk),
		.wr_en   (in_acc && (s_tuser == ACT_LOAD)),
		.wr_addr (entry_index),
		.wr_data (entry_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sabs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (in_acc && (s_tuser == ACT_SEARCH)),
		.target      (search_target),
		.out_free    (out_free),
		.rd_data     (rd_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.idle        (seq_idle),
		.done        (seq_done),
		.result      (seq_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			if (seq_done) begin
				m_tvalid_q <= 1'b1;
				out_q      <= seq_result;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.probe_count, out_q.position, out_q.found});

`ifndef ASSERT_OFF
	a_busy_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_SEARCH) |=> !s_tready)
		else $error("input ready right after a search item was taken");

	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> $past(out_free))
		else $error("search result finished while the output register was full");

	a_hit_has_probe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.found |-> out_q.probe_count != '0)
		else $error("hit reported without any probe");

	a_miss_position: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_q.found |-> out_q.position == '0)
		else $error("failed search reports a nonzero position");
`endif

endmodule

// ----- design/sabs_store.sv -----
// Value store with one write port and one registered read port.
`timescale 1ns / 1ps
module sabs_store
	import sabs_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [VAL_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [VAL_W-1:0]  rd_data
);

	logic [VAL_W-1:0] mem_q [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/sabs_seq.sv -----
// Search sequencer with the shared midpoint, bound update and compare unit.
`timescale 1ns / 1ps
module sabs_seq
	import sabs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic              start,
	input  logic [VAL_W-1:0]  target,
	input  logic              out_free,
	input  logic [VAL_W-1:0]  rd_data,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	output logic              idle,
	output logic              done,
	output sabs_result_t      result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP,
		ST_FIN
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         element_count_q;
	logic [VAL_W-1:0]         target_q;
	logic [LO_W-1:0]          lo_q;
	logic signed [BND_W-1:0]  hi_q;
	logic [ADDR_W-1:0]        mid_q;
	logic [PRB_W-1:0]         probes_q;
	logic                     found_q;
	logic [ADDR_W-1:0]        pos_q;
	logic                     done_q;

	logic [BND_W-1:0]         count_sat;
	logic [BND_W-1:0]         mid_sum;
	logic [ADDR_W-1:0]        mid;
	logic                     in_range;
	logic                     val_eq;
	logic                     val_lt;

	assign count_sat = (32'(element_count_q) > 32'(DEPTH)) ? BND_W'(DEPTH)
		: BND_W'(element_count_q);
	assign in_range  = $signed({1'b0, lo_q}) <= hi_q;
	assign mid_sum   = BND_W'(lo_q) + BND_W'(hi_q);
	assign mid       = ADDR_W'(mid_sum >> 1);
	assign val_eq    = rd_data == target_q;
	assign val_lt    = $signed(rd_data) < $signed(target_q);

	assign rd_en   = (state_q == ST_CHECK) && in_range;
	assign rd_addr = mid;
	assign idle    = state_q == ST_IDLE;
	assign done    = done_q;
	assign result  = '{found: found_q, position: pos_q, probe_count: probes_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_wr_en) begin
			element_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			probes_q <= '0;
			found_q  <= 1'b0;
			pos_q    <= '0;
			target_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						target_q <= target;
						lo_q     <= '0;
						hi_q     <= $signed(count_sat) - BND_W'(1);
						probes_q <= '0;
						found_q  <= 1'b0;
						pos_q    <= '0;
						state_q  <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_range) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CMP: begin
					if (probes_q != PRB_MAX) begin
						probes_q <= probes_q + PRB_W'(1);
					end
					if (val_eq) begin
						found_q <= 1'b1;
						pos_q   <= mid_q;
						state_q <= ST_FIN;
					end else begin
						if (val_lt) begin
							lo_q <= LO_W'(mid_q) + LO_W'(1);
						end else begin
							hi_q <= $signed(BND_W'(mid_q)) - BND_W'(1);
						end
						state_q <= ST_CHECK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- test/sorted_array_binary_search_tb.sv -----
// Self-checking testbench for the sorted array binary search block.
`timescale 1ns / 1ps
module sorted_array_binary_search_tb
	import sabs_pkg::*;
;

	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 950;

	typedef struct {
		logic                     action;
		logic [ADDR_W-1:0]        index;
		logic signed [VAL_W-1:0]  value;
		logic signed [VAL_W-1:0]  target;
	} request_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]       cfg_wr_data = '0;

	request_t     pending_items[$];
	sabs_result_t expected_results[$];

	logic signed [VAL_W-1:0] model_store [DEPTH];
	int  model_count = 0;
	int  mismatches = 0;
	int  send_idle_pct = 0;
	int  sink_idle_pct = 0;
	int  hold_requests = 0;
	int  holds_done = 0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	logic in_taken = 1'b0;

	wire [ADDR_W-1:0]       in_index  = s_tdata[ADDR_W-1:0];
	wire signed [VAL_W-1:0] in_value  = s_tdata[ADDR_W+VAL_W-1:ADDR_W];
	wire signed [VAL_W-1:0] in_target = s_tdata[ADDR_W+2*VAL_W-1:ADDR_W+VAL_W];
	wire                    out_found    = m_tdata[0];
	wire [ADDR_W-1:0]       out_position = m_tdata[ADDR_W:1];
	wire [PRB_W-1:0]        out_probes   = m_tdata[ADDR_W+PRB_W:ADDR_W+1];

	sorted_array_binary_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sabs_result_t search_table(logic signed [VAL_W-1:0] target);
		int lo;
		int hi;
		int mid;
		int probes;
		sabs_result_t r;
		r = '0;
		probes = 0;
		lo = 0;
		hi = ((model_count > DEPTH) ? DEPTH : model_count) - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (probes < PRB_MAX)
				probes++;
			if (model_store[mid] == target) begin
				r.found = 1'b1;
				r.position = mid[ADDR_W-1:0];
				break;
			end
			if (model_store[mid] < target)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		r.probe_count = probes[PRB_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0d ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Input side: offer the next pending item, holding it until it is taken.
	always @(negedge clk) begin
		request_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			s_tvalid <= 1'b1;
		end else if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
			it = pending_items.pop_front();
			s_tvalid <= 1'b1;
			s_tuser <= it.action;
			s_tdata <= IN_TDATA_W'({it.target, it.value, it.index});
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Output side: random back-pressure, plus long hold-offs on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			m_tready <= 1'b0;
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		sabs_result_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			if (s_tuser == ACT_LOAD)
				model_store[in_index] = in_value;
			else
				expected_results.push_back(search_table(in_target));
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = expected_results.pop_front();
				if (out_found !== want.found)
					report_mismatch("found", out_found, want.found);
				if (out_position !== want.position)
					report_mismatch("position", out_position, want.position);
				if (out_probes !== want.probe_count)
					report_mismatch("probe_count", out_probes, want.probe_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_load(int index, logic signed [VAL_W-1:0] value);
		request_t it;
		it.action = ACT_LOAD;
		it.index = index[ADDR_W-1:0];
		it.value = value;
		it.target = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic push_search(logic signed [VAL_W-1:0] target);
		request_t it;
		it.action = ACT_SEARCH;
		it.index = $urandom;
		it.value = $urandom;
		it.target = target;
		pending_items.push_back(it);
	endtask

	task automatic settle();
		@(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(int count);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count[CNT_W-1:0];
		model_count = count;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Loads an ascending table into entries 0 to size-1, either spread over
	// the whole range or packed tightly so that duplicates and neighbors occur.
	task automatic load_table(int size);
		longint unsigned stride;
		longint cur;
		int unsigned step_max;
		stride = 64'hFFFF_FFFF / (size + 1);
		if ($urandom_range(1, 0) == 1)
			stride = $urandom_range(4, 1);
		step_max = stride[31:0];
		cur = -64'sd2147483648 + $urandom_range(step_max, 0);
		for (int i = 0; i < size; i++) begin
			push_load(i, cur[VAL_W-1:0]);
			cur += $urandom_range(step_max, 0);
		end
	endtask

	task automatic push_searches(int size, int amount, int loaded_prefix);
		int k;
		logic signed [VAL_W-1:0] t;
		for (int i = 0; i < amount; i++) begin
			k = $urandom_range(size - 1, 0);
			case ($urandom_range(4, 0))
				0, 1, 2: t = model_store[k];
				3: t = model_store[k] + (($urandom_range(1, 0) == 1) ? 1 : -1);
				default: t = $urandom;
			endcase
			push_search(t);
			if (loaded_prefix != 0 && $urandom_range(7, 0) == 0)
				push_load($urandom_range(loaded_prefix - 1, 0), $urandom);
		end
	endtask

	initial begin
		int random_items;
		int loaded_prefix;
		int size;
		int amount;
		int count;

		send_idle_pct = 13;
		sink_idle_pct = 88;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store: every search fails without a probe.
		push_search(0);
		push_search(-32'sd2147483647 - 1);
		settle();

		push_load(0, -32'sd2147483647 - 1);
		push_load(1, -5);
		push_load(2, 0);
		push_load(3, 7);
		push_load(4, 32'sd2147483647);
		settle();
		write_count(5);
		push_search(-32'sd2147483647 - 1);
		push_search(32'sd2147483647);
		push_search(-5);
		push_search(0);
		push_search(7);
		push_search(3);
		push_search(8);
		settle();

		write_count(1);
		push_search(-32'sd2147483647 - 1);
		push_search(32'sd2147483647);
		settle();

		// Break the ordering and search across it.
		write_count(5);
		push_load(2, 100);
		push_search(7);
		push_search(100);
		settle();

		loaded_prefix = 5;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 16) begin
				send_idle_pct = 13;
				sink_idle_pct = 88;
			end else if (random_items < RANDOM_ITEMS / 8) begin
				send_idle_pct = 88;
				sink_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				sink_idle_pct = 0;
			end

			if (random_items >= RANDOM_ITEMS / 8) begin
				load_table(DEPTH);
				loaded_prefix = DEPTH;
				settle();
				write_count(DEPTH);
				hold_requests++;
				push_searches(DEPTH, 40, loaded_prefix);
				settle();
				write_count(2047);
				push_searches(DEPTH, 12, loaded_prefix);
				settle();
				write_count(1500);
				push_searches(DEPTH, 8, loaded_prefix);
				settle();
				random_items += DEPTH + 60;
			end else begin
				size = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 49)
					: $urandom_range(48, 1);
				load_table(size);
				if (size > loaded_prefix)
					loaded_prefix = size;
				settle();
				case ($urandom_range(9, 0))
					0: count = 0;
					1: count = $urandom_range(size, 0);
					2: count = (loaded_prefix == DEPTH) ? $urandom_range(2047, DEPTH + 1) : size;
					default: count = size;
				endcase
				write_count(count);
				amount = $urandom_range(20, 4);
				push_searches(size, amount, loaded_prefix);
				settle();
				random_items += size + amount;
			end
		end

		if (expected_results.size() != 0)
			report_mismatch("missing results", 0, expected_results.size());
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
